// ===== src/ssht_pkg.sv =====
// Shared types and constants for the sensor slot health tracker.
// Used by every module of the block; depends on nothing else.
package ssht_pkg;

    // Field widths of the input and result items.
    localparam int ACTION_W  = 2;
    localparam int SLOT_W    = 4;
    localparam int STATE_W   = 2;
    localparam int COUNT_W   = 7;
    localparam int READING_W = 12;
    localparam int S_DATA_W  = 24;
    localparam int M_DATA_W  = 32;

    // Default bank size and limits.
    localparam int SLOTS_DEFAULT = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 7'd127;
    localparam logic [COUNT_W-1:0] LIMIT_RESET = 7'd3;

    // Action codes carried in tuser.
    localparam logic [ACTION_W-1:0] ACT_INIT   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_START  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ   = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    // Identity states of a slot.
    localparam logic [STATE_W-1:0] ID_UNKNOWN = 2'd0;
    localparam logic [STATE_W-1:0] ID_OK      = 2'd1;
    localparam logic [STATE_W-1:0] ID_ABSENT  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // load the accepted transaction into the input register
        logic commit;   // update the slot record and load the result register
    } dp_cmd_t;

endpackage

// ===== src/ssht_ctrl.sv =====
// Controller of the sensor slot health tracker: handshakes and sequencing.
// Depends on ssht_pkg; drives the datapath through ssht_pkg::dp_cmd_t.
module ssht_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output ssht_pkg::dp_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    // The result register can take a new result when empty or being drained.
    assign out_free = !out_valid_reg || m_tready;

    // Sequencing: take one transaction, then process it once the output is free.
    always_comb begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        s_tready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid flag: set by a new result, cleared when the result is taken.
    always_comb begin
        if (cmd.commit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

// ===== src/ssht_datapath.sv =====
// Datapath of the sensor slot health tracker: slot records, update rules,
// error limit register and result register. Depends on ssht_pkg.
module ssht_datapath #(
    parameter int SLOTS = ssht_pkg::SLOTS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  ssht_pkg::dp_cmd_t                   cmd,
    input  logic [ssht_pkg::S_DATA_W-1:0]       s_tdata,
    input  logic [ssht_pkg::ACTION_W-1:0]       s_tuser,
    input  logic                                cfg_write,
    input  logic [ssht_pkg::COUNT_W-1:0]        cfg_data,
    output logic [ssht_pkg::M_DATA_W-1:0]       m_tdata
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Input register holding the transaction being processed.
    logic [ssht_pkg::ACTION_W-1:0]         action_reg;
    logic [ssht_pkg::SLOT_W-1:0]           slot_reg;
    logic                                  found_reg;
    logic                                  start_ok_reg;
    logic                                  read_ok_reg;
    logic signed [ssht_pkg::READING_W-1:0] reading_reg;

    // Per-slot records and the error limit.
    logic [ssht_pkg::STATE_W-1:0]          id_state_reg [SLOTS];
    logic [ssht_pkg::COUNT_W-1:0]          err_cnt_reg  [SLOTS];
    logic signed [ssht_pkg::READING_W-1:0] stored_reg   [SLOTS];
    logic                                  valid_reg    [SLOTS];
    logic [ssht_pkg::COUNT_W-1:0]          limit_reg;

    logic [ssht_pkg::M_DATA_W-1:0]         result_reg, result_next;

    // Working values of the update.
    logic                                  in_range;
    logic [IDX_W-1:0]                      idx;
    logic [ssht_pkg::STATE_W-1:0]          st_cur, st_new;
    logic [ssht_pkg::COUNT_W-1:0]          cnt_cur, cnt_new;
    logic signed [ssht_pkg::READING_W-1:0] rdg_new;
    logic                                  vld_cur, vld_new;
    logic                                  searched, success, alarm, have_id;

    assign in_range = ({1'b0, slot_reg} < (ssht_pkg::SLOT_W + 1)'(SLOTS));
    assign idx      = slot_reg[IDX_W-1:0];

    // Capture the accepted transaction.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            action_reg   <= s_tuser;
            slot_reg     <= s_tdata[3:0];
            found_reg    <= s_tdata[4];
            start_ok_reg <= s_tdata[5];
            read_ok_reg  <= s_tdata[6];
            reading_reg  <= s_tdata[18:7];
        end
    end

    // Apply the action to the addressed slot's record.
    always_comb begin
        st_cur   = id_state_reg[idx];
        cnt_cur  = err_cnt_reg[idx];
        vld_cur  = valid_reg[idx];
        rdg_new  = stored_reg[idx];
        searched = 1'b0;
        success  = 1'b0;
        alarm    = 1'b0;
        have_id  = 1'b1;

        // Init first clears the record.
        if (action_reg == ssht_pkg::ACT_INIT) begin
            st_cur  = ssht_pkg::ID_UNKNOWN;
            cnt_cur = '0;
            vld_cur = 1'b0;
        end
        st_new  = st_cur;
        cnt_new = cnt_cur;
        vld_new = vld_cur;

        if (action_reg != ssht_pkg::ACT_UNUSED) begin
            // Identity search when asked, when identity is lost, or on too many errors.
            if (action_reg == ssht_pkg::ACT_INIT || st_cur != ssht_pkg::ID_OK ||
                cnt_cur >= limit_reg) begin
                searched = 1'b1;
                st_new   = found_reg ? ssht_pkg::ID_OK : ssht_pkg::ID_ABSENT;
            end
            have_id = !searched || found_reg;

            unique case (action_reg)
                ssht_pkg::ACT_INIT: begin
                    success = found_reg;
                end
                ssht_pkg::ACT_START: begin
                    success = have_id && start_ok_reg;
                end
                default: begin
                    // Read action.
                    if (!have_id) begin
                        vld_new = 1'b0;
                        alarm   = 1'b1;
                    end else if (read_ok_reg) begin
                        cnt_new = '0;
                        rdg_new = reading_reg;
                        vld_new = 1'b1;
                        success = 1'b1;
                    end else begin
                        if (cnt_cur < ssht_pkg::COUNT_MAX) begin
                            cnt_new = cnt_cur + 7'd1;
                        end
                        if (cnt_new > limit_reg) begin
                            vld_new = 1'b0;
                            alarm   = 1'b1;
                        end
                    end
                end
            endcase
        end

        // Result word; a slot outside the bank reports only its number.
        if (in_range) begin
            result_next = {3'b000, alarm, vld_new, rdg_new, cnt_new, st_new,
                           success, searched, slot_reg};
        end else begin
            result_next = {28'd0, slot_reg};
        end
    end

    // Slot records, cleared at reset, written back on commit for a slot inside the bank.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < SLOTS; k++) begin
                id_state_reg[k] <= ssht_pkg::ID_UNKNOWN;
                err_cnt_reg[k]  <= '0;
                stored_reg[k]   <= '0;
                valid_reg[k]    <= 1'b0;
            end
        end else if (cmd.commit && in_range) begin
            id_state_reg[idx] <= st_new;
            err_cnt_reg[idx]  <= cnt_new;
            stored_reg[idx]   <= rdg_new;
            valid_reg[idx]    <= vld_new;
        end
    end

    // Error limit register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= ssht_pkg::LIMIT_RESET;
        end else if (cfg_write) begin
            limit_reg <= cfg_data;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            result_reg <= result_next;
        end
    end

    assign m_tdata = result_reg;

endmodule

// ===== src/sensor_slot_health_tracker.sv =====
// Top level of the sensor slot health tracker.
// Depends on ssht_pkg, ssht_ctrl and ssht_datapath.
//
// Usage:
//   The s_ channel carries one request per transaction: tuser holds the
//   action (init, start, read), tdata the slot and the bus outcomes. The m_
//   channel returns exactly one result per request with the slot's record
//   after the update. The user writes the error limit on the cfg_ channel
//   only while the block is idle; the block itself does not enforce this.
//   The cfg_ channel is always ready.
// Operation:
//   A taken request waits in the input register until the output register
//   is free; one read-modify-write then updates the slot record and loads
//   the result. The block holds one request at a time.
// Reset:
//   All slots return to unknown identity, zero errors and an invalid zero
//   reading; the error limit returns to 3. No result is pending.
// Stall:
//   While the receiver holds m_tready low the result stays in place; one
//   further request is taken and then waits until the result is taken.
module sensor_slot_health_tracker #(
    parameter int SLOTS = ssht_pkg::SLOTS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Request channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: slot[3:0], search_found[4], start_ok[5], read_ok[6],
    //        reading[18:7], zero[23:19]
    input  logic [23:0] s_tdata,
    // tuser: action[1:0]
    input  logic [1:0]  s_tuser,
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: slot_out[3:0], searched[4], success[5], identity_status[7:6],
    //        fail_count[14:8], held_reading[26:15], reading_valid[27],
    //        sensor_alarm[28], zero[31:29]
    output logic [31:0] m_tdata,
    // Error limit write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data
);

    ssht_pkg::dp_cmd_t cmd;

    assign cfg_ready = 1'b1;

    ssht_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    ssht_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== src/ssht_checker.sv =====
// Port-level checks for the sensor slot health tracker, with the bind that
// attaches them to the top level. Depends on sensor_slot_health_tracker.
module ssht_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // No result is pending right after reset.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result holds its value.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // One request at a time: the block is busy in the cycle after a transaction.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    // A new result appears only while a request was in work.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result without request");

    // An alarm never comes with success or with a valid reading.
    a_alarm_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[28] |-> !m_tdata[5] && !m_tdata[27])
        else $error("alarm with success or valid reading");

endmodule

bind sensor_slot_health_tracker ssht_checker u_ssht_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
